// File: hw/rtl/aais_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area-average image shrink package
// Shared widths, codes, request and result types, overlap helper.
// ----------------------------------------------------------------------------
package aais_pkg;

	localparam int PW    = 20;  // source/destination coordinates in 1/out units
	localparam int NUMW  = 34;  // divider dividend
	localparam int DENW  = 25;  // divider divisor
	localparam int MAW   = 13;  // multiplier operand a
	localparam int MBW   = 24;  // multiplier operand b
	localparam int SUMW  = 32;  // weighted channel sums
	localparam int AREAW = 24;  // covered area
	localparam int OVW   = 12;  // one-axis overlap

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	localparam logic [1:0] TM_NONE = 2'd0;
	localparam logic [1:0] TM_LE   = 2'd1;
	localparam logic [1:0] TM_GE   = 2'd2;
	localparam logic [1:0] TM_KEY  = 2'd3;

	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_X_IN   = 3'd2;
	localparam logic [2:0] CFG_X_OUT  = 3'd3;
	localparam logic [2:0] CFG_Y_IN   = 3'd4;
	localparam logic [2:0] CFG_Y_OUT  = 3'd5;
	localparam logic [2:0] CFG_MODE   = 3'd6;
	localparam logic [2:0] CFG_KEY    = 3'd7;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RATIO = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic       command;
		logic [6:0] pos_x;
		logic [6:0] pos_y;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		status_t    status;
	} res_t;

	function automatic logic [OVW-1:0] ovl(input logic [PW-1:0] a0, input logic [PW-1:0] a1,
		input logic [PW-1:0] b0, input logic [PW-1:0] b1);
		logic [PW-1:0] lo;
		logic [PW-1:0] hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a1 < b1) ? a1 : b1;
		ovl = (hi > lo) ? OVW'(hi - lo) : '0;
	endfunction

endpackage

// File: hw/rtl/area_average_image_shrink.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Area-average image shrink
// Box-filter downscaler: stores an RGBA source image, returns one averaged
// destination pixel per compute request.
// ----------------------------------------------------------------------------
// A write request is stored without raising busy. A compute request
// holds busy high while one sequencer drives a shared multiplier and a
// restoring divider (with operand load and hand-off around each division):
// six divisions for the destination size and covered span, then per covered
// source pixel one store read, one weight product, four channel products and
// the alpha sum, plus a row setup per covered row, then four divisions for
// the averages. A bad ratio ends without any division; an out-of-range
// position ends after the two size divisions. The result is shown for
// exactly one cycle with done high, and the receiver must take it then; it
// cannot stall the block.
// ----------------------------------------------------------------------------
module area_average_image_shrink #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  aais_pkg::req_t   req,
	output logic             done,
	output aais_pkg::res_t   res,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [23:0]      cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = aais_pkg::PW;

	localparam logic [3:0] PH_WN = 4'd0;
	localparam logic [3:0] PH_HN = 4'd1;
	localparam logic [3:0] PH_XF = 4'd2;
	localparam logic [3:0] PH_XL = 4'd3;
	localparam logic [3:0] PH_YF = 4'd4;
	localparam logic [3:0] PH_YL = 4'd5;
	localparam logic [3:0] PH_R  = 4'd6;
	localparam logic [3:0] PH_G  = 4'd7;
	localparam logic [3:0] PH_B  = 4'd8;
	localparam logic [3:0] PH_A  = 4'd9;

	localparam logic [2:0] MAC_LAST = 3'd4;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_CHK  = 14'b00000000000010,
		S_PREP = 14'b00000000000100,
		S_DLD  = 14'b00000000001000,
		S_DIV  = 14'b00000000010000,
		S_LS1  = 14'b00000000100000,
		S_LS2  = 14'b00000001000000,
		S_LS3  = 14'b00000010000000,
		S_LS4  = 14'b00000100000000,
		S_ROW  = 14'b00001000000000,
		S_PIX  = 14'b00010000000000,
		S_WT   = 14'b00100000000000,
		S_MAC  = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	// configuration
	logic [7:0]  cw_q, ch_q;
	logic [11:0] xin_q, xout_q, yin_q, yout_q;
	logic [1:0]  mode_q;
	logic [23:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q   <= 8'd128;
			ch_q   <= 8'd128;
			xin_q  <= 12'd2;
			xout_q <= 12'd1;
			yin_q  <= 12'd2;
			yout_q <= 12'd1;
			mode_q <= aais_pkg::TM_NONE;
			key_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				aais_pkg::CFG_WIDTH:  cw_q   <= cfg_data[7:0];
				aais_pkg::CFG_HEIGHT: ch_q   <= cfg_data[7:0];
				aais_pkg::CFG_X_IN:   xin_q  <= cfg_data[11:0];
				aais_pkg::CFG_X_OUT:  xout_q <= cfg_data[11:0];
				aais_pkg::CFG_Y_IN:   yin_q  <= cfg_data[11:0];
				aais_pkg::CFG_Y_OUT:  yout_q <= cfg_data[11:0];
				aais_pkg::CFG_MODE:   mode_q <= cfg_data[1:0];
				aais_pkg::CFG_KEY:    key_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [7:0] w_c, h_c;
	assign w_c = (int'(cw_q) > MAX_WIDTH)  ? 8'(MAX_WIDTH)  : cw_q;
	assign h_c = (int'(ch_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : ch_q;

	// state
	state_t                        state_q;
	logic [3:0]                    phase_q;
	logic [2:0]                    cnt_q;
	logic                          done_q;
	aais_pkg::res_t                res_q;
	aais_pkg::status_t             stat_q;
	logic [6:0]                    px_q, py_q;
	logic [PW-1:0]                 wn_q, xf_q, xl_q, yf_q, yl_q;
	logic [PW-1:0]                 pxl_q, pxh_q, pyl_q, pyh_q;
	logic [PW-1:0]                 xlo0_q, xlo_q, ylo_q, xs_q, ys_q;
	logic [AW-1:0]                 rowbase_q;
	logic [aais_pkg::OVW-1:0]      wx_q, wy_q;
	logic [aais_pkg::AREAW-1:0]    wt_q, area_q, tarea_q;
	logic [aais_pkg::SUMW-1:0]     sr_q, sg_q, sb_q, sa_q;
	logic [aais_pkg::MAW+aais_pkg::MBW-1:0] mul_q;
	logic [7:0]                    r_q, g_q, b_q, a_q;

	assign busy = (state_q != S_IDLE);

	// source store
	logic          st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [31:0]   rd;

	assign st_we = start && !busy && (req.command == aais_pkg::CMD_WRITE) &&
		(int'(req.pos_x) < MAX_WIDTH) && (int'(req.pos_y) < MAX_HEIGHT);
	assign st_waddr = AW'(int'(req.pos_y) * MAX_WIDTH + int'(req.pos_x));
	assign st_raddr = rowbase_q + AW'(xs_q);

	aais_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata ({req.in_red, req.in_green, req.in_blue, req.in_alpha}),
		.raddr (st_raddr),
		.rdata (rd)
	);

	// transparency of the pixel just read
	logic trans;
	always_comb begin
		case (mode_q)
			aais_pkg::TM_LE:  trans = rd[7:0] <= key_q[7:0];
			aais_pkg::TM_GE:  trans = rd[7:0] >= key_q[7:0];
			aais_pkg::TM_KEY: trans = (rd[31:8] == key_q);
			default:          trans = 1'b0;
		endcase
	end

	// shared multiplier
	logic [aais_pkg::MAW-1:0] op_a;
	logic [aais_pkg::MBW-1:0] op_b;
	logic [aais_pkg::MAW+aais_pkg::MBW-1:0] prod;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_PREP: begin
				case (phase_q)
					PH_WN: begin op_a = 13'(xout_q); op_b = 24'(w_c); end
					PH_HN: begin op_a = 13'(yout_q); op_b = 24'(h_c); end
					PH_XF: begin op_a = 13'(xin_q); op_b = 24'(px_q); end
					PH_XL: begin op_a = 13'(xin_q); op_b = 24'(px_q) + 24'd1; end
					PH_YF: begin op_a = 13'(yin_q); op_b = 24'(py_q); end
					PH_YL: begin op_a = 13'(yin_q); op_b = 24'(py_q) + 24'd1; end
					default: ;
				endcase
			end
			S_LS1: begin op_a = 13'(xout_q); op_b = 24'(xf_q); end
			S_LS2: begin op_a = 13'(yout_q); op_b = 24'(yf_q); end
			S_LS3: begin op_a = 13'(MAX_WIDTH); op_b = 24'(yf_q); end
			S_WT:  begin op_a = 13'(wx_q); op_b = 24'(wy_q); end
			S_MAC: begin
				op_b = wt_q;
				case (cnt_q)
					3'd0:    op_a = 13'(rd[31:24]);
					3'd1:    op_a = 13'(rd[23:16]);
					3'd2:    op_a = 13'(rd[15:8]);
					default: op_a = 13'(rd[7:0]);
				endcase
			end
			default: ;
		endcase
	end

	assign prod = op_a * op_b;

	// divider operands
	logic [aais_pkg::AREAW-1:0] cden;
	logic [aais_pkg::NUMW-1:0]  d_num, qv;
	logic [aais_pkg::DENW-1:0]  d_den;
	logic                       d_skip, div_done, adv;
	logic [aais_pkg::NUMW-1:0]  quot;

	assign cden = area_q - tarea_q;

	always_comb begin
		d_num = mul_q[aais_pkg::NUMW-1:0];
		d_den = '0;
		case (phase_q)
			PH_WN: begin d_num = d_num + 34'(xin_q) - 34'd1; d_den = 25'(xin_q); end
			PH_HN: begin d_num = d_num + 34'(yin_q) - 34'd1; d_den = 25'(yin_q); end
			PH_XF: d_den = 25'(xout_q);
			PH_XL: begin d_num = d_num + 34'(xout_q) - 34'd1; d_den = 25'(xout_q); end
			PH_YF: d_den = 25'(yout_q);
			PH_YL: begin d_num = d_num + 34'(yout_q) - 34'd1; d_den = 25'(yout_q); end
			PH_R: begin d_num = {1'b0, sr_q, 1'b0} + 34'(cden); d_den = {cden, 1'b0}; end
			PH_G: begin d_num = {1'b0, sg_q, 1'b0} + 34'(cden); d_den = {cden, 1'b0}; end
			PH_B: begin d_num = {1'b0, sb_q, 1'b0} + 34'(cden); d_den = {cden, 1'b0}; end
			default: begin d_num = {1'b0, sa_q, 1'b0} + 34'(area_q); d_den = {area_q, 1'b0}; end
		endcase
	end

	assign d_skip = (d_den == '0);
	assign adv    = ((state_q == S_DLD) && d_skip) || ((state_q == S_DIV) && div_done);
	assign qv     = d_skip ? '0 : quot;

	aais_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == S_DLD) && !d_skip),
		.num    (d_num),
		.den    (d_den),
		.done   (div_done),
		.quot   (quot)
	);

	logic [PW-1:0] qp;
	assign qp = qv[PW-1:0];

	logic [PW-1:0] xs_n, ys_n;
	assign xs_n = xs_q + 1'b1;
	assign ys_n = ys_q + 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_WN;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && req.command == aais_pkg::CMD_COMPUTE) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					phase_q <= PH_WN;
					if (xin_q == '0 || xout_q == '0 || yin_q == '0 || yout_q == '0 ||
						xout_q > xin_q || yout_q > yin_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_DLD;
				S_DLD: begin
					if (!d_skip) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: ;
				S_LS1: state_q <= S_LS2;
				S_LS2: state_q <= S_LS3;
				S_LS3: state_q <= S_LS4;
				S_LS4: begin
					if (yf_q < yl_q && xf_q < xl_q) begin
						state_q <= S_ROW;
					end else begin
						phase_q <= PH_R;
						state_q <= S_PREP;
					end
				end
				S_ROW: state_q <= S_PIX;
				S_PIX: state_q <= S_WT;
				S_WT: begin
					cnt_q   <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MAC_LAST) begin
						if (xs_n < xl_q) begin
							state_q <= S_PIX;
						end else if (ys_n < yl_q) begin
							state_q <= S_ROW;
						end else begin
							phase_q <= PH_R;
							state_q <= S_PREP;
						end
					end
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (adv) begin
				case (phase_q)
					PH_HN: begin
						if (PW'(px_q) >= wn_q || PW'(py_q) >= qp) begin
							state_q <= S_OUT;
						end else begin
							phase_q <= phase_q + 1'b1;
							state_q <= S_PREP;
						end
					end
					PH_YL: state_q <= S_LS1;
					PH_A:  state_q <= S_OUT;
					default: begin
						phase_q <= phase_q + 1'b1;
						state_q <= S_PREP;
					end
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q <= req.pos_x;
				py_q <= req.pos_y;
			end
			S_CHK: begin
				area_q  <= '0;
				tarea_q <= '0;
				sr_q    <= '0;
				sg_q    <= '0;
				sb_q    <= '0;
				sa_q    <= '0;
				if (xin_q == '0 || xout_q == '0 || yin_q == '0 || yout_q == '0 ||
					xout_q > xin_q || yout_q > yin_q) begin
					stat_q <= aais_pkg::STAT_RATIO;
				end else begin
					stat_q <= aais_pkg::STAT_OK;
				end
			end
			S_PREP: mul_q <= prod;
			S_DLD: begin
				case (phase_q)
					PH_XF: pxl_q <= mul_q[PW-1:0];
					PH_XL: pxh_q <= mul_q[PW-1:0];
					PH_YF: pyl_q <= mul_q[PW-1:0];
					PH_YL: pyh_q <= mul_q[PW-1:0];
					default: ;
				endcase
			end
			S_LS1: mul_q <= prod;
			S_LS2: begin
				xlo0_q <= mul_q[PW-1:0];
				mul_q  <= prod;
			end
			S_LS3: begin
				ylo_q <= mul_q[PW-1:0];
				mul_q <= prod;
			end
			S_LS4: begin
				rowbase_q <= mul_q[AW-1:0];
				ys_q      <= yf_q;
			end
			S_ROW: begin
				wy_q  <= aais_pkg::ovl(pyl_q, pyh_q, ylo_q, ylo_q + PW'(yout_q));
				xs_q  <= xf_q;
				xlo_q <= xlo0_q;
			end
			S_PIX: wx_q <= aais_pkg::ovl(pxl_q, pxh_q, xlo_q, xlo_q + PW'(xout_q));
			S_WT:  wt_q <= prod[aais_pkg::AREAW-1:0];
			S_MAC: begin
				if (cnt_q != MAC_LAST) begin
					mul_q <= prod;
				end
				case (cnt_q)
					3'd0: begin
						area_q <= area_q + wt_q;
						if (trans) begin
							tarea_q <= tarea_q + wt_q;
						end
					end
					3'd1: if (!trans) sr_q <= sr_q + mul_q[aais_pkg::SUMW-1:0];
					3'd2: if (!trans) sg_q <= sg_q + mul_q[aais_pkg::SUMW-1:0];
					3'd3: if (!trans) sb_q <= sb_q + mul_q[aais_pkg::SUMW-1:0];
					default: begin
						sa_q  <= sa_q + mul_q[aais_pkg::SUMW-1:0];
						xs_q  <= xs_n;
						xlo_q <= xlo_q + PW'(xout_q);
						if (xs_n >= xl_q) begin
							ys_q      <= ys_n;
							ylo_q     <= ylo_q + PW'(yout_q);
							rowbase_q <= rowbase_q + AW'(MAX_WIDTH);
						end
					end
				endcase
			end
			default: ;
		endcase
		if (adv) begin
			case (phase_q)
				PH_WN: wn_q <= qp;
				PH_HN: if (PW'(px_q) >= wn_q || PW'(py_q) >= qp) stat_q <= aais_pkg::STAT_RANGE;
				PH_XF: xf_q <= qp;
				PH_XL: xl_q <= (qp > PW'(w_c)) ? PW'(w_c) : qp;
				PH_YF: yf_q <= qp;
				PH_YL: yl_q <= (qp > PW'(h_c)) ? PW'(h_c) : qp;
				PH_R:  r_q <= qv[7:0];
				PH_G:  g_q <= qv[7:0];
				PH_B:  b_q <= qv[7:0];
				default: a_q <= qv[7:0];
			endcase
		end
		if (state_q == S_OUT) begin
			res_q.status <= stat_q;
			if (stat_q != aais_pkg::STAT_OK) begin
				res_q.out_red   <= '0;
				res_q.out_green <= '0;
				res_q.out_blue  <= '0;
				res_q.out_alpha <= '0;
			end else begin
				res_q.out_alpha <= a_q;
				if (mode_q == aais_pkg::TM_KEY && a_q <= 8'd127) begin
					res_q.out_red   <= key_q[23:16];
					res_q.out_green <= key_q[15:8];
					res_q.out_blue  <= key_q[7:0];
				end else begin
					res_q.out_red   <= r_q;
					res_q.out_green <= g_q;
					res_q.out_blue  <= b_q;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a compute in progress");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("still busy after result");

	a_error_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status != aais_pkg::STAT_OK) |->
		(res.out_red == 8'd0 && res.out_green == 8'd0 && res.out_blue == 8'd0 &&
		res.out_alpha == 8'd0))
		else $error("error result carries colour");

endmodule

// File: hw/rtl/aais_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source pixel store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module aais_store #(
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]              rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/aais_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module aais_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [aais_pkg::NUMW-1:0] num,
	input  logic [aais_pkg::DENW-1:0] den,
	output logic                      done,
	output logic [aais_pkg::NUMW-1:0] quot
);

	localparam int CW = $clog2(aais_pkg::NUMW);

	logic [aais_pkg::NUMW-1:0] q_q;
	logic [aais_pkg::DENW-1:0] rem_q;
	logic [aais_pkg::DENW-1:0] den_q;
	logic [CW-1:0]             cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [aais_pkg::DENW:0]   shl;
	logic [aais_pkg::DENW:0]   diff;
	logic                      ge;

	assign shl  = {rem_q, q_q[aais_pkg::NUMW-1]};
	assign diff = shl - {1'b0, den_q};
	assign ge   = shl >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(aais_pkg::NUMW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[aais_pkg::DENW-1:0] : shl[aais_pkg::DENW-1:0];
			q_q   <= {q_q[aais_pkg::NUMW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule
